FILE: rtl/wsfp_pkg.sv
// shared types, constants and helpers for the websocket frame parser
`default_nettype none

package wsfp_pkg;

    // width of the payload byte counter; lengths beyond it saturate
    localparam int LENGTH_BITS = 64;

    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    // one result beat
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_payload;
        logic        header_done;
        logic        final_flag;
        logic [2:0]  reserved_bits;
        logic [3:0]  frame_opcode;
        logic        masked_flag;
        logic [63:0] payload_length;
        logic        frame_end;
        logic        message_end;
    } result_t;

    // clamp a decoded length to the counter range
    function automatic logic [63:0] sat_len(input logic [63:0] len);
        logic [63:0] res;
        begin
            res = (len > LEN_MAX) ? LEN_MAX : len;
            return res;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wsfp_parse_core.sv
// header walker, length decode and payload unmasking for one byte per cycle while fire is high
`default_nettype none

module wsfp_parse_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       byte_in,
    output wsfp_pkg::result_t     res
);
    import wsfp_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [7:0]               header_reg, header_next;
    logic                     mask_reg, mask_next;
    logic [63:0]              length_reg, length_next;
    logic [2:0]               sub_reg, sub_next;
    logic [31:0]              key_reg, key_next;
    logic [LENGTH_BITS-1:0]   remain_reg, remain_next;
    logic [LENGTH_BITS-1:0]   remain_dec;
    logic [1:0]               kidx_reg, kidx_next;

    logic                     len_done;
    logic [63:0]              len_cand;
    logic [63:0]              len_sat;
    logic                     hdr_fin;
    logic [63:0]              fin_len;
    logic                     is_payload;
    logic                     frame_end;
    logic [7:0]               key_byte;
    logic [7:0]               ob;

    assign remain_dec = remain_reg - 1'b1;

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        sub_next    = sub_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        len_done    = 1'b0;
        len_cand    = length_reg;
        len_sat     = '0;
        hdr_fin     = 1'b0;
        fin_len     = length_reg;
        is_payload  = 1'b0;
        frame_end   = 1'b0;
        ob          = byte_in;

        case (phase_reg)
            PH_SECOND:
            begin
                mask_next = byte_in[7];
                sub_next  = '0;
                if (byte_in[6:0] == LEN_CODE_EXT16)
                begin
                    length_next = '0;
                    phase_next  = PH_EXT16;
                end
                else if (byte_in[6:0] == LEN_CODE_EXT64)
                begin
                    length_next = '0;
                    phase_next  = PH_EXT64;
                end
                else
                begin
                    len_done = 1'b1;
                    len_cand = {57'd0, byte_in[6:0]};
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_cand    = {length_reg[55:0], byte_in};
                length_next = len_cand;
                if (sub_reg == ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                    len_done = 1'b1;
                else
                    sub_next = sub_reg + 3'd1;
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], byte_in};
                if (sub_reg >= KEY_LAST)
                begin
                    sub_next = '0;
                    hdr_fin  = 1'b1;
                    fin_len  = length_reg;
                end
                else
                    sub_next = sub_reg + 3'd1;
            end
            PH_PAYLOAD:
            begin
                is_payload  = 1'b1;
                if (mask_reg)
                    ob = byte_in ^ key_byte;
                kidx_next   = kidx_reg + 2'd1;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    frame_end  = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                header_next = byte_in;
                mask_next   = 1'b0;
                phase_next  = PH_SECOND;
            end
        endcase

        // length complete: go to key or finish header
        if (len_done)
        begin
            len_sat     = sat_len(len_cand);
            length_next = len_sat;
            sub_next    = '0;
            if (mask_next)
                phase_next = PH_KEY;
            else
            begin
                hdr_fin = 1'b1;
                fin_len = len_sat;
            end
        end

        // header complete: empty frame ends here, else enter payload
        if (hdr_fin)
        begin
            if (fin_len == '0)
            begin
                frame_end  = 1'b1;
                phase_next = PH_FIRST;
            end
            else
            begin
                remain_next = fin_len[LENGTH_BITS-1:0];
                kidx_next   = '0;
                phase_next  = PH_PAYLOAD;
            end
        end

        res.out_byte       = ob;
        res.is_payload     = is_payload;
        res.header_done    = hdr_fin;
        res.final_flag     = header_next[7];
        res.reserved_bits  = header_next[6:4];
        res.frame_opcode   = header_next[3:0];
        res.masked_flag    = mask_next;
        res.payload_length = hdr_fin ? fin_len : 64'd0;
        res.frame_end      = frame_end;
        res.message_end    = frame_end & header_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            header_reg <= '0;
            mask_reg   <= 1'b0;
            length_reg <= '0;
            sub_reg    <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            kidx_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            mask_reg   <= mask_next;
            length_reg <= length_next;
            sub_reg    <= sub_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_parser_unit.sv
// top level of the websocket frame parser: input register, parse core, result register
`default_nettype none

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | sink      | in_valid / in_stall | stream_byte
//  out     | source    | out_valid/out_stall | out_byte, is_payload, header_done,
//          |           |                     | final_flag, reserved_bits, frame_opcode,
//          |           |                     | masked_flag, payload_length, frame_end,
//          |           |                     | message_end
//
//  one beat in, one beat out; sustained rate is one byte per clock while out_stall is low
//  a byte passes the input register, then the single parse pass into the result register
//  the parse state updates only when the input register hands its byte to the result register
//  rst_n clears the parse state and both valid flags; payload registers are not reset
//  out_stall holds the result register, and in_stall rises only once both registers are full

module websocket_frame_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  stream_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_payload,
    output logic             header_done,
    output logic             final_flag,
    output logic [2:0]       reserved_bits,
    output logic [3:0]       frame_opcode,
    output logic             masked_flag,
    output logic [63:0]      payload_length,
    output logic             frame_end,
    output logic             message_end
);
    import wsfp_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // result register
    logic        out_valid_reg;
    result_t     res_reg;

    result_t     res_comb;
    logic        out_free;
    logic        fire;
    logic        in_take;

    // result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // byte in the input register is parsed and moves on
    assign fire     = in_valid_reg && out_free;
    // input register is free when empty or moving on
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    wsfp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (in_byte_reg),
        .res     (res_comb)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= stream_byte;
        if (fire)
            res_reg <= res_comb;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = res_reg.out_byte;
    assign is_payload     = res_reg.is_payload;
    assign header_done    = res_reg.header_done;
    assign final_flag     = res_reg.final_flag;
    assign reserved_bits  = res_reg.reserved_bits;
    assign frame_opcode   = res_reg.frame_opcode;
    assign masked_flag    = res_reg.masked_flag;
    assign payload_length = res_reg.payload_length;
    assign frame_end      = res_reg.frame_end;
    assign message_end    = res_reg.message_end;

endmodule

`default_nettype wire

FILE: tb/websocket_frame_parser_unit_tb.sv
// testbench for the websocket frame parser: directed byte table, then random frames, all scored
`timescale 1ns / 100ps

module websocket_frame_parser_unit_tb;
    import wsfp_pkg::*;

    // how the length of a generated frame is encoded on the wire
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } form_t;

    // receiver back-pressure styles, picked at random by the receiver process
    typedef enum logic [2:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC,
        RX_BLOCKS
    } rx_mode_t;

    // one row of the stimulus table; typed rows carry a hand-written expectation
    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } stim_row_t;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 1880;
    localparam int PRINT_CAP    = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = 8'h00;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        is_payload;
    logic        header_done;
    logic        final_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] payload_length;
    logic        frame_end;
    logic        message_end;

    stim_row_t   stream_rows[$];
    result_t     results_due[$];
    int          send_idx = 0;
    int          beat_count = 0;
    int          err_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          rx_tick = 0;
    rx_mode_t    rx_mode = RX_OPEN;

    // deframer state, mirrors the block after reset
    phase_t      ph = PH_FIRST;
    logic [7:0]  hdr_byte = 8'h00;
    logic        mask_on = 1'b0;
    logic [63:0] len_acc = 64'd0;
    logic [2:0]  ext_cnt = 3'd0;
    logic [31:0] key_word = 32'd0;
    logic [63:0] remain = 64'd0;
    logic [1:0]  key_pos = 2'd0;

    websocket_frame_parser_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_payload     (is_payload),
        .header_done    (header_done),
        .final_flag     (final_flag),
        .reserved_bits  (reserved_bits),
        .frame_opcode   (frame_opcode),
        .masked_flag    (masked_flag),
        .payload_length (payload_length),
        .frame_end      (frame_end),
        .message_end    (message_end)
    );

    always #6 clk = ~clk;

    // advance the deframer by one stream byte and return the result beat it yields
    function automatic result_t deframe_step(input logic [7:0] b);
        result_t    r;
        logic [7:0] ob;
        logic       pay;
        logic       hdr_done;
        logic       fend;
        logic       mask_known;
        logic       len_done;
        logic       hdr_fin;
        begin
            ob = b;
            pay = 1'b0;
            hdr_done = 1'b0;
            fend = 1'b0;
            mask_known = 1'b1;
            len_done = 1'b0;
            hdr_fin = 1'b0;
            case (ph)
                PH_SECOND:
                begin
                    mask_on = b[7];
                    ext_cnt = 3'd0;
                    if (b[6:0] == LEN_CODE_EXT16)
                    begin
                        len_acc = 64'd0;
                        ph = PH_EXT16;
                    end
                    else if (b[6:0] == LEN_CODE_EXT64)
                    begin
                        len_acc = 64'd0;
                        ph = PH_EXT64;
                    end
                    else
                    begin
                        len_acc = {57'd0, b[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    // big-endian: each byte shifts in at the bottom
                    len_acc = {len_acc[55:0], b};
                    if (ext_cnt == ((ph == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                        len_done = 1'b1;
                    else
                        ext_cnt = ext_cnt + 3'd1;
                end
                PH_KEY:
                begin
                    key_word = {key_word[23:0], b};
                    if (ext_cnt >= KEY_LAST)
                    begin
                        ext_cnt = 3'd0;
                        hdr_fin = 1'b1;
                    end
                    else
                        ext_cnt = ext_cnt + 3'd1;
                end
                PH_PAYLOAD:
                begin
                    pay = 1'b1;
                    // first key byte sits in the top of the key word
                    if (mask_on)
                        ob = b ^ key_word[8 * (3 - key_pos) +: 8];
                    key_pos = key_pos + 2'd1;
                    remain = remain - 64'd1;
                    if (remain == 64'd0)
                    begin
                        fend = 1'b1;
                        ph = PH_FIRST;
                    end
                end
                default:
                begin
                    // first header byte: mask flag not seen yet
                    hdr_byte = b;
                    mask_on = 1'b0;
                    mask_known = 1'b0;
                    ph = PH_SECOND;
                end
            endcase

            if (len_done)
            begin
                if (len_acc > LEN_MAX)
                    len_acc = LEN_MAX;
                ext_cnt = 3'd0;
                if (mask_on)
                    ph = PH_KEY;
                else
                    hdr_fin = 1'b1;
            end

            if (hdr_fin)
            begin
                hdr_done = 1'b1;
                // an empty frame closes on its last header byte
                if (len_acc == 64'd0)
                begin
                    fend = 1'b1;
                    ph = PH_FIRST;
                end
                else
                begin
                    remain = len_acc;
                    key_pos = 2'd0;
                    ph = PH_PAYLOAD;
                end
            end

            r.out_byte = ob;
            r.is_payload = pay;
            r.header_done = hdr_done;
            r.final_flag = hdr_byte[7];
            r.reserved_bits = hdr_byte[6:4];
            r.frame_opcode = hdr_byte[3:0];
            r.masked_flag = mask_known ? mask_on : 1'b0;
            r.payload_length = hdr_done ? len_acc : 64'd0;
            r.frame_end = fend;
            r.message_end = fend & hdr_byte[7];
            return r;
        end
    endfunction

    function automatic result_t make_result(input logic [7:0] ob, input logic pay,
                                            input logic hd, input logic fin,
                                            input logic [2:0] rsv, input logic [3:0] op,
                                            input logic m, input logic [63:0] len,
                                            input logic fe, input logic me);
        result_t r;
        begin
            r.out_byte = ob;
            r.is_payload = pay;
            r.header_done = hd;
            r.final_flag = fin;
            r.reserved_bits = rsv;
            r.frame_opcode = op;
            r.masked_flag = m;
            r.payload_length = len;
            r.frame_end = fe;
            r.message_end = me;
            return r;
        end
    endfunction

    function automatic void add_row(input logic [7:0] d, input bit typed, input result_t want);
        stim_row_t row;
        begin
            row.data = d;
            row.typed = typed;
            row.want = want;
            stream_rows.push_back(row);
        end
    endfunction

    function automatic void add_byte(input logic [7:0] d);
        add_row(d, 1'b0, '0);
    endfunction

    // append a whole frame; payload bytes beyond cap are left out
    function automatic void queue_frame(input logic [7:0] first, input logic masked,
                                        input logic [63:0] len, input form_t form,
                                        input int cap);
        logic [6:0] code;
        int         n;
        int         i;
        begin
            if (form == FORM_SHORT)
                code = len[6:0];
            else if (form == FORM_EXT16)
                code = LEN_CODE_EXT16;
            else
                code = LEN_CODE_EXT64;
            add_byte(first);
            add_byte({masked, code});
            if (form == FORM_EXT16)
            begin
                add_byte(len[15:8]);
                add_byte(len[7:0]);
            end
            else if (form == FORM_EXT64)
            begin
                for (i = 7; i >= 0; i--)
                    add_byte(len[8 * i +: 8]);
            end
            if (masked)
            begin
                for (i = 0; i < 4; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
            n = (len > 64'(cap)) ? cap : int'(len);
            for (i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic report(input string msg);
        begin
            err_count++;
            if (err_count <= PRINT_CAP)
                $display("tb: beat %0d %s", beat_count, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        begin
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // sender, scoreboard and watchdog share one clocked process so that
    // accepting an input and retiring a result on the same edge stay ordered
    always @(posedge clk)
    begin
        logic    fire_in;
        logic    fire_out;
        result_t guess;
        result_t want;
        if (rst_n)
        begin
            fire_in = in_valid && !in_stall;
            fire_out = out_valid && !out_stall;

            // accepted input beat: predict its result and queue it
            if (fire_in)
            begin
                guess = deframe_step(stream_rows[send_idx].data);
                results_due.push_back(stream_rows[send_idx].typed ?
                                      stream_rows[send_idx].want : guess);
                send_idx++;
            end

            // accepted result beat: compare with the oldest expectation
            if (fire_out)
            begin
                if (results_due.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = results_due.pop_front();
                    check_field("out_byte", 64'(out_byte), 64'(want.out_byte));
                    check_field("is_payload", 64'(is_payload), 64'(want.is_payload));
                    check_field("header_done", 64'(header_done), 64'(want.header_done));
                    check_field("final_flag", 64'(final_flag), 64'(want.final_flag));
                    check_field("reserved_bits", 64'(reserved_bits),
                                64'(want.reserved_bits));
                    check_field("frame_opcode", 64'(frame_opcode), 64'(want.frame_opcode));
                    check_field("masked_flag", 64'(masked_flag), 64'(want.masked_flag));
                    check_field("payload_length", payload_length, want.payload_length);
                    check_field("frame_end", 64'(frame_end), 64'(want.frame_end));
                    check_field("message_end", 64'(message_end), 64'(want.message_end));
                end
                beat_count++;
            end

            // a stalled beat holds; otherwise walk the table in bursts with gaps
            if (in_valid && !fire_in)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (send_idx < stream_rows.size())
            begin
                in_valid <= 1'b1;
                stream_byte <= stream_rows[send_idx].data;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                in_valid <= 1'b0;

            // watchdog: count cycles in which no beat moves on either side
            if (fire_in || fire_out)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: watchdog, no beat for %0d cycles", idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver back-pressure: rx_tick sets when a new random style is picked
    always @(posedge clk)
    begin
        logic nxt;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            rx_tick++;
            if (rx_tick % 96 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 4));
            case (rx_mode)
                RX_LIGHT:    nxt = ($urandom_range(0, 3) == 0);
                RX_HEAVY:    nxt = ($urandom_range(0, 3) != 0);
                RX_PERIODIC: nxt = ((rx_tick % 8) < 3);
                RX_BLOCKS:   nxt = ((rx_tick % 32) >= 20);
                default:     nxt = 1'b0;
            endcase
            out_stall <= nxt;
        end
    end

    initial
    begin
        logic [63:0] len;
        logic [63:0] huge;
        int          pick;
        form_t       form;
        logic        msk;

        // directed table
        // masked empty final text frame, header-only frame end on the last key byte
        add_row(8'h81, 1'b1, make_result(8'h81, 1'b0, 1'b0, 1'b1, 3'd0, 4'h1, 1'b0, 64'd0,
                                         1'b0, 1'b0));
        add_row(8'h80, 1'b1, make_result(8'h80, 1'b0, 1'b0, 1'b1, 3'd0, 4'h1, 1'b1, 64'd0,
                                         1'b0, 1'b0));
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hA5);
        add_row(8'h5A, 1'b1, make_result(8'h5A, 1'b0, 1'b1, 1'b1, 3'd0, 4'h1, 1'b1, 64'd0,
                                         1'b1, 1'b1));
        // all reserved bits and the top opcode, unmasked empty frame ends on byte two
        add_row(8'h7F, 1'b1, make_result(8'h7F, 1'b0, 1'b0, 1'b0, 3'd7, 4'hF, 1'b0, 64'd0,
                                         1'b0, 1'b0));
        add_row(8'h00, 1'b1, make_result(8'h00, 1'b0, 1'b1, 1'b0, 3'd7, 4'hF, 1'b0, 64'd0,
                                         1'b1, 1'b0));
        // masked control frame: payload is unmasked for a control opcode as well
        add_byte(8'h8A);
        add_byte(8'h82);
        add_byte(8'h12);
        add_byte(8'h34);
        add_byte(8'h56);
        add_byte(8'h78);
        add_byte(8'hFF);
        add_byte(8'h00);
        // non-minimal 16-bit length of one, unmasked payload passes unchanged
        add_byte(8'h02);
        add_byte(8'h7E);
        add_byte(8'h00);
        add_row(8'h01, 1'b1, make_result(8'h01, 1'b0, 1'b1, 1'b0, 3'd0, 4'h2, 1'b0, 64'd1,
                                         1'b0, 1'b0));
        add_byte(8'hC3);

        // random well-formed frames with random header bits and contents
        while (stream_rows.size() < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                len = 64'd0;
            else if (pick < 60)
                len = 64'($urandom_range(1, 20));
            else if (pick < 82)
                len = 64'($urandom_range(21, 125));
            else
                len = 64'($urandom_range(126, 400));
            pick = $urandom_range(0, 99);
            if (len < 64'd126)
                form = (pick < 80) ? FORM_SHORT : (pick < 92) ? FORM_EXT16 : FORM_EXT64;
            else
                form = (pick < 75) ? FORM_EXT16 : FORM_EXT64;
            msk = ($urandom_range(0, 9) < 7);
            queue_frame(8'($urandom_range(0, 255)), msk, len, form, 1000);
        end

        // last: a 64-bit length with its top bit set, only the start of it sent
        huge = {32'($urandom), 32'($urandom)} | 64'h8000_0000_0000_0000;
        queue_frame(8'($urandom_range(0, 255)), 1'b1, huge, FORM_EXT64, 40);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (send_idx == stream_rows.size() && results_due.size() == 0);
        // two-stage pipe: wait on to catch any stray result
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wsfp_pkg.sv
rtl/wsfp_parse_core.sv
rtl/websocket_frame_parser_unit.sv
tb/websocket_frame_parser_unit_tb.sv
